// File: sv/lwss_pkg.sv
// Shared types and constants of the loss window stability scorer.
`default_nettype none
package lwss_pkg;

  localparam int LOSS_W = 16;
  localparam int TIME_W = 48;
  localparam int INST_W = 17;
  localparam int BKT_W  = 2;
  localparam int FILL_W = 9;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 8;
  localparam int WGT_W  = 8;
  localparam int A_W    = 22;
  localparam int SXX_W  = 46;
  localparam int SXY_W  = 32;
  localparam int SYY_W  = 18;
  localparam int P_W    = 64;
  localparam int Q_W    = 32;
  localparam int MIN_SAMPLES = 30;

  localparam logic [31:0]     SPREAD_RESET  = 32'd214748365;
  localparam logic [31:0]     TWIN_RESET    = 32'd1000000;
  localparam logic [31:0]     RECALC_RESET  = 32'd1700000;
  localparam logic [INST_W-1:0] ONE_Q16     = 17'd65536;

  localparam logic [IDX_W-1:0] REG_TIME_WINDOW = 8'd0;
  localparam logic [IDX_W-1:0] REG_RECALC      = 8'd1;
  localparam logic [IDX_W-1:0] REG_W_LOW       = 8'd2;
  localparam logic [IDX_W-1:0] REG_W_MID       = 8'd3;
  localparam logic [IDX_W-1:0] REG_W_HIGH      = 8'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SPCHK, ST_SUM_RD, ST_SUM_ACC, ST_VMUL1, ST_VMUL2, ST_VDIV_LD,
    ST_VDIV, ST_VSAT, ST_BUCKET, ST_FRD, ST_FEV, ST_PUSH, ST_ARD, ST_ACHK,
    ST_SIM0, ST_SIM_ACC, ST_PMUL1, ST_PMUL2, ST_SQRT, ST_SQ_FIN, ST_CDIV,
    ST_CFIN, ST_OUT
  } lwss_step_t;

  typedef struct packed {
    lwss_step_t step;
    logic       accept;
  } lwss_cmd_t;

  typedef struct packed {
    logic recalc;
    logic enough;
    logic full;
    logic last;
    logic age_evict;
    logic few;
    logic sxy_zero;
    logic q_zero;
    logic out_free;
  } lwss_sts_t;

endpackage
`default_nettype wire

// File: sv/loss_window_stability_scorer.sv
// Top level of the loss window stability scorer.
//
//  channel | direction | payload
//  in_     | slave     | tdata[15:0] loss_fraction, [63:16] sample_time
//  out_    | master    | tdata[16:0] instability, [18:17] bucket_chosen, [27:19] window_fill
//  cfg_    | slave     | cfg_index register, cfg_data value
//
// One transaction at a time, built around the 32-step square root and the shared
// radix-2 divider (51 steps), with extra steps for each evicted sample.
// A spread recompute adds a pass over every history entry.
// Reset (rst_n, synchronous) restores registers and empties the window.
// The finished result sits in the output register; the next transaction is taken meanwhile.
`default_nettype none
module loss_window_stability_scorer
  import lwss_pkg::*;
#(
  parameter int HISTORY_DEPTH = 512,
  parameter int WINDOW_DEPTH  = 256
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire  [63:0]        in_tdata,   // loss_fraction, sample_time
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [31:0]        out_tdata,  // instability, bucket_chosen, window_fill
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [IDX_W-1:0]   cfg_index,
  input  wire  [CFG_W-1:0]   cfg_data
);

  lwss_cmd_t         cmd;
  lwss_sts_t         sts;
  logic [INST_W-1:0] inst;
  logic [BKT_W-1:0]  bkt;
  logic [FILL_W-1:0] fill;

  assign cfg_ready = 1'b1;
  assign out_tdata = {4'h0, fill, bkt, inst};

  lwss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lwss_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .WINDOW_DEPTH  (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_loss   (in_tdata[15:0]),
    .in_time   (in_tdata[63:16]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_inst  (inst),
    .out_bkt   (bkt),
    .out_fill  (fill)
  );

endmodule
`default_nettype wire

// File: sv/lwss_ctrl.sv
// Sequencer of the loss window stability scorer.
`default_nettype none
module lwss_ctrl
  import lwss_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_tvalid,
  output logic      in_tready,
  input  lwss_sts_t sts,
  output lwss_cmd_t cmd
);

  lwss_step_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_tvalid) state_nxt = ST_SPCHK;
      ST_SPCHK:   state_nxt = (sts.recalc && sts.enough) ? ST_SUM_RD : ST_BUCKET;
      ST_SUM_RD:  state_nxt = ST_SUM_ACC;
      ST_SUM_ACC: state_nxt = sts.last ? ST_VMUL1 : ST_SUM_RD;
      ST_VMUL1:   state_nxt = ST_VMUL2;
      ST_VMUL2:   state_nxt = ST_VDIV_LD;
      ST_VDIV_LD: state_nxt = ST_VDIV;
      ST_VDIV:    if (sts.last) state_nxt = ST_VSAT;
      ST_VSAT:    state_nxt = ST_BUCKET;
      ST_BUCKET:  state_nxt = sts.full ? ST_FRD : ST_PUSH;
      ST_FRD:     state_nxt = ST_FEV;
      ST_FEV:     state_nxt = ST_PUSH;
      ST_PUSH:    state_nxt = ST_ARD;
      ST_ARD:     state_nxt = ST_ACHK;
      ST_ACHK:    state_nxt = sts.age_evict ? ST_ARD : ST_SIM0;
      ST_SIM0:    state_nxt = sts.few ? ST_OUT : ST_SIM_ACC;
      ST_SIM_ACC: if (sts.last) state_nxt = ST_PMUL1;
      ST_PMUL1:   state_nxt = sts.sxy_zero ? ST_OUT : ST_PMUL2;
      ST_PMUL2:   state_nxt = ST_SQRT;
      ST_SQRT:    if (sts.last) state_nxt = ST_SQ_FIN;
      ST_SQ_FIN:  state_nxt = sts.q_zero ? ST_OUT : ST_CDIV;
      ST_CDIV:    if (sts.last) state_nxt = ST_CFIN;
      ST_CFIN:    state_nxt = ST_OUT;
      ST_OUT:     if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    cmd.step   = state_r;
    cmd.accept = (state_r == ST_IDLE) && in_tvalid;
  end

endmodule
`default_nettype wire

// File: sv/lwss_dp.sv
// Datapath: history ring, time window, spread, similarity and result register.
`default_nettype none
module lwss_dp
  import lwss_pkg::*;
#(
  parameter int HISTORY_DEPTH = 512,
  parameter int WINDOW_DEPTH  = 256
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  lwss_cmd_t                  cmd,
  output lwss_sts_t                  sts,
  input  wire  [LOSS_W-1:0]          in_loss,
  input  wire  [TIME_W-1:0]          in_time,
  input  wire                        cfg_we,
  input  wire  [IDX_W-1:0]           cfg_idx,
  input  wire  [CFG_W-1:0]           cfg_val,
  input  wire                        out_ready,
  output logic                       out_valid,
  output logic [INST_W-1:0]          out_inst,
  output logic [BKT_W-1:0]           out_bkt,
  output logic [FILL_W-1:0]          out_fill
);

  localparam int HAW  = $clog2(HISTORY_DEPTH);
  localparam int CW   = HAW + 1;
  localparam int S1W  = LOSS_W + HAW;
  localparam int S2W  = 2 * LOSS_W + HAW;
  localparam int NUMW = 2 * HAW + 2 * LOSS_W + 1;
  localparam int CDW  = SXY_W + 16;
  localparam int DIVW = (NUMW > CDW) ? NUMW : CDW;
  localparam int WAW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WCW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUMW = LOSS_W + WCW;
  localparam int EW   = BKT_W + LOSS_W + TIME_W;

  // configuration
  logic [31:0]      twin_r, recalc_r;
  logic [WGT_W-1:0] wgt_r [3];

  // history ring
  logic [LOSS_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [LOSS_W-1:0] hist_rd_r;
  logic [HAW-1:0]    pos_r;
  logic              wrapped_r;
  logic [CW-1:0]     n_w;

  // window queue
  logic [EW-1:0]   win_mem [WINDOW_DEPTH];
  logic [EW-1:0]   win_rd_r;
  logic [WAW-1:0]  head_r, tail_w;
  logic [WCW-1:0]  cnt_win_r;
  logic [WCW:0]    tail_sum;
  logic [SUMW-1:0] sum_r [3];

  // item registers
  logic [LOSS_W-1:0] x_r;
  logic [TIME_W-1:0] t_r;
  logic [BKT_W-1:0]  bkt_r;
  logic [INST_W-1:0] res_r;
  logic [31:0]       spread_r;
  logic [TIME_W-1:0] last_r;

  // arithmetic
  logic [CW-1:0]    cnt_r;
  logic [S1W-1:0]   s1_r;
  logic [S2W-1:0]   s2_r;
  logic [NUMW-1:0]  m1_r, m2_r;
  logic [2*HAW:0]   den_r;
  logic [DIVW-1:0]  dv_n_r;
  logic [Q_W-1:0]   dv_d_r, dv_rem_r;
  logic [Q_W:0]     dv_tmp;
  logic             dv_ge;
  logic [A_W-1:0]   a_r [3];
  logic [SXX_W-1:0] sxx_r;
  logic [SXY_W-1:0] sxy_r;
  logic [SYY_W-1:0] syy_r;
  logic [P_W-1:0]   p_r;
  logic [Q_W+2:0]   sq_rem_r, sq_r2, sq_trial;
  logic [Q_W-1:0]   sq_root_r;
  logic             sq_ge;

  // combinational helpers
  logic [1:0]        k_w;
  logic [TIME_W-1:0] age_w, since_w;
  logic [33:0]       xq_w;
  logic [BKT_W-1:0]  bkt_w;
  logic [SUMW-1:0]   maxa_w;
  logic [4:0]        sh_w;
  logic [BKT_W-1:0]  ev_b;
  logic [LOSS_W-1:0] ev_x;
  logic [DIVW-1:0]   cap_w;
  logic              out_load;

  assign n_w      = wrapped_r ? CW'(HISTORY_DEPTH) : {1'b0, pos_r};
  assign tail_sum = {1'b0, head_r} + {1'b0, cnt_win_r};
  assign tail_w   = (tail_sum >= (WCW+1)'(WINDOW_DEPTH)) ?
                    WAW'(tail_sum - (WCW+1)'(WINDOW_DEPTH)) : WAW'(tail_sum);
  assign k_w      = cnt_r[1:0];
  assign age_w    = t_r - win_rd_r[TIME_W-1:0];
  assign since_w  = t_r - last_r;
  assign xq_w     = {2'b00, x_r, 16'h0000};
  assign ev_b     = win_rd_r[EW-1 -: BKT_W];
  assign ev_x     = win_rd_r[TIME_W +: LOSS_W];
  assign dv_tmp   = {dv_rem_r, dv_n_r[DIVW-1]};
  assign dv_ge    = dv_tmp >= {1'b0, dv_d_r};
  assign sq_r2    = {sq_rem_r[Q_W:0], p_r[P_W-1 -: 2]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign sq_ge    = sq_r2 >= sq_trial;
  assign cap_w    = (dv_n_r > DIVW'(ONE_Q16)) ? DIVW'(ONE_Q16) : dv_n_r;
  assign out_load = (cmd.step == ST_OUT) && sts.out_free;

  always_comb begin
    if (xq_w <= {1'b0, spread_r, 1'b0}) begin
      bkt_w = 2'd0;
    end else if (xq_w <= {spread_r, 2'b00}) begin
      bkt_w = 2'd1;
    end else begin
      bkt_w = 2'd2;
    end
  end

  always_comb begin
    maxa_w = sum_r[0];
    if (sum_r[1] > maxa_w) maxa_w = sum_r[1];
    if (sum_r[2] > maxa_w) maxa_w = sum_r[2];
    sh_w = '0;
    for (int i = A_W; i < SUMW; i++) begin
      if (maxa_w[i]) sh_w = 5'(i - A_W + 1);
    end
  end

  always_comb begin
    sts.recalc    = since_w > {16'h0000, recalc_r};
    sts.enough    = n_w >= CW'(MIN_SAMPLES);
    sts.full      = cnt_win_r == WCW'(WINDOW_DEPTH);
    sts.age_evict = (cnt_win_r != '0) && (age_w > {16'h0000, twin_r});
    sts.few       = cnt_win_r < WCW'(2);
    sts.sxy_zero  = sxy_r == '0;
    sts.q_zero    = sq_root_r == '0;
    sts.out_free  = !out_valid || out_ready;
    case (cmd.step)
      ST_SUM_ACC:         sts.last = cnt_r == (n_w - CW'(1));
      ST_VDIV, ST_CDIV:   sts.last = cnt_r == CW'(DIVW - 1);
      ST_SQRT:            sts.last = cnt_r == CW'(Q_W - 1);
      ST_SIM_ACC:         sts.last = cnt_r == CW'(2);
      default:            sts.last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) hist_mem[pos_r] <= in_loss;
    hist_rd_r <= hist_mem[cnt_r[HAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.step == ST_PUSH) win_mem[tail_w] <= {bkt_r, x_r, t_r};
    win_rd_r <= win_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      twin_r    <= TWIN_RESET;
      recalc_r  <= RECALC_RESET;
      wgt_r[0]  <= 8'd0;
      wgt_r[1]  <= 8'd1;
      wgt_r[2]  <= 8'd4;
      pos_r     <= '0;
      wrapped_r <= 1'b0;
      spread_r  <= SPREAD_RESET;
      last_r    <= '0;
      head_r    <= '0;
      cnt_win_r <= '0;
      sum_r[0]  <= '0;
      sum_r[1]  <= '0;
      sum_r[2]  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TIME_WINDOW: twin_r   <= cfg_val;
          REG_RECALC:      recalc_r <= cfg_val;
          REG_W_LOW:       wgt_r[0] <= cfg_val[WGT_W-1:0];
          REG_W_MID:       wgt_r[1] <= cfg_val[WGT_W-1:0];
          REG_W_HIGH:      wgt_r[2] <= cfg_val[WGT_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.step)
        ST_IDLE: begin
          if (cmd.accept) begin
            x_r <= in_loss;
            t_r <= in_time;
            if (pos_r == HAW'(HISTORY_DEPTH - 1)) begin
              pos_r     <= '0;
              wrapped_r <= 1'b1;
            end else begin
              pos_r <= pos_r + HAW'(1);
            end
          end
        end
        ST_SPCHK: begin
          if (sts.recalc) last_r <= t_r;
          cnt_r <= '0;
          s1_r  <= '0;
          s2_r  <= '0;
        end
        ST_SUM_ACC: begin
          s1_r  <= s1_r + S1W'(hist_rd_r);
          s2_r  <= s2_r + S2W'(hist_rd_r) * S2W'(hist_rd_r);
          cnt_r <= cnt_r + CW'(1);
        end
        ST_VMUL1: begin
          m1_r  <= NUMW'(n_w) * NUMW'(s2_r);
          den_r <= (2*HAW+1)'(n_w) * (2*HAW+1)'(n_w - CW'(1));
        end
        ST_VMUL2: m2_r <= NUMW'(s1_r) * NUMW'(s1_r);
        ST_VDIV_LD: begin
          dv_n_r   <= DIVW'(m1_r - m2_r);
          dv_d_r   <= Q_W'(den_r);
          dv_rem_r <= '0;
          cnt_r    <= '0;
        end
        ST_VDIV, ST_CDIV: begin
          dv_rem_r <= dv_ge ? Q_W'(dv_tmp - {1'b0, dv_d_r}) : dv_tmp[Q_W-1:0];
          dv_n_r   <= {dv_n_r[DIVW-2:0], dv_ge};
          cnt_r    <= cnt_r + CW'(1);
        end
        ST_VSAT: spread_r <= (dv_n_r > DIVW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : dv_n_r[31:0];
        ST_BUCKET: bkt_r <= bkt_w;
        ST_FEV, ST_ACHK: begin
          if (cmd.step == ST_FEV || sts.age_evict) begin
            sum_r[ev_b] <= sum_r[ev_b] - SUMW'(ev_x);
            head_r      <= (head_r == WAW'(WINDOW_DEPTH - 1)) ? '0 : head_r + WAW'(1);
            cnt_win_r   <= cnt_win_r - WCW'(1);
          end
        end
        ST_PUSH: begin
          cnt_win_r    <= cnt_win_r + WCW'(1);
          sum_r[bkt_r] <= sum_r[bkt_r] + SUMW'(x_r);
        end
        ST_SIM0: begin
          res_r <= ONE_Q16;
          for (int i = 0; i < 3; i++) a_r[i] <= A_W'(sum_r[i] >> sh_w);
          sxx_r <= '0;
          sxy_r <= '0;
          syy_r <= '0;
          cnt_r <= '0;
        end
        ST_SIM_ACC: begin
          sxx_r <= sxx_r + SXX_W'(a_r[k_w]) * SXX_W'(a_r[k_w]);
          sxy_r <= sxy_r + SXY_W'(a_r[k_w]) * SXY_W'(wgt_r[k_w]);
          syy_r <= syy_r + SYY_W'(wgt_r[k_w]) * SYY_W'(wgt_r[k_w]);
          cnt_r <= cnt_r + CW'(1);
        end
        ST_PMUL1: p_r <= P_W'(sxx_r[22:0]) * P_W'(syy_r);
        ST_PMUL2: begin
          p_r       <= p_r + ((P_W'(sxx_r[SXX_W-1:23]) * P_W'(syy_r)) << 23);
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          cnt_r     <= '0;
        end
        ST_SQRT: begin
          sq_rem_r  <= sq_ge ? sq_r2 - sq_trial : sq_r2;
          sq_root_r <= {sq_root_r[Q_W-2:0], sq_ge};
          p_r       <= {p_r[P_W-3:0], 2'b00};
          cnt_r     <= cnt_r + CW'(1);
        end
        ST_SQ_FIN: begin
          res_r    <= '0;
          dv_n_r   <= DIVW'({sxy_r, 16'h0000});
          dv_d_r   <= sq_root_r;
          dv_rem_r <= '0;
          cnt_r    <= '0;
        end
        ST_CFIN: res_r <= ONE_Q16 - INST_W'(cap_w);
        ST_OUT: begin
          if (out_load) begin
            out_inst <= res_r;
            out_bkt  <= bkt_r;
            out_fill <= FILL_W'(cnt_win_r);
          end
        end
        default: ;
      endcase
    end
  end

  a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_win_r <= WCW'(WINDOW_DEPTH)) else $error("window count overflow");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid) else $error("result lost");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == ST_PUSH) |-> !sts.full) else $error("push into full window");
  a_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bkt != 2'd3)) else $error("bad bucket");

endmodule
`default_nettype wire

// File: sim/tb_loss_window_stability_scorer.sv
// Testbench for the loss window stability scorer: predicts and checks each result.
`timescale 1ns / 1ps
`default_nettype none
module tb_loss_window_stability_scorer;
  import lwss_pkg::*;

  localparam int HIST_N = 512;
  localparam int WIN_N  = 256;
  localparam longint unsigned LIMIT_CYCLES = 64'd20000000;
  localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  wire in_tready;
  logic [63:0] in_tdata = '0;
  wire out_tvalid;
  logic out_tready = 1'b0;
  wire [31:0] out_tdata;
  logic cfg_valid = 1'b0;
  wire cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  loss_window_stability_scorer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct packed {
    logic [INST_W-1:0] instability;
    logic [BKT_W-1:0]  bucket;
    logic [FILL_W-1:0] fill;
  } score_t;

  // predictor state
  logic [31:0] p_twin, p_recalc;
  logic [31:0] p_wgt [3];
  logic [15:0] p_hist [HIST_N];
  int unsigned p_rpos;
  bit p_wrapped;
  logic [31:0] p_spread;
  logic [47:0] p_last_recalc;
  logic [15:0] p_wval [WIN_N];
  logic [1:0]  p_wbkt [WIN_N];
  logic [47:0] p_wtime [WIN_N];
  int unsigned p_head, p_count;
  logic [31:0] p_sums [3];

  score_t expected_scores[$];
  bit failed = 1'b0;
  bit quiet = 1'b0;
  longint unsigned cycles = 0;
  logic [47:0] now_us = '0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic model_reset();
    p_twin = TWIN_RESET;
    p_recalc = RECALC_RESET;
    p_wgt[0] = 0; p_wgt[1] = 1; p_wgt[2] = 4;
    p_rpos = 0;
    p_wrapped = 0;
    p_spread = SPREAD_RESET;
    p_last_recalc = '0;
    p_head = 0;
    p_count = 0;
    for (int i = 0; i < 3; i++) p_sums[i] = 0;
  endtask

  task automatic drop_oldest();
    p_sums[p_wbkt[p_head]] -= p_wval[p_head];
    p_head = (p_head + 1) % WIN_N;
    p_count--;
  endtask

  function automatic logic [INST_W-1:0] similarity_score();
    longint unsigned maxa, sxx, syy, sxy, q, c, a, w;
    int s;
    maxa = 0; sxx = 0; syy = 0; sxy = 0; s = 0;
    if (p_count < 2) return ONE_Q16;
    for (int i = 0; i < 3; i++) if (p_sums[i] > maxa) maxa = p_sums[i];
    while ((maxa >> s) >= (64'd1 << 22)) s++;
    for (int i = 0; i < 3; i++) begin
      w = p_wgt[i];
      a = p_sums[i] >> s;
      sxx += a * a;
      syy += w * w;
      sxy += a * w;
    end
    if (sxy == 0) return ONE_Q16;
    q = int_sqrt(sxx * syy);
    if (q == 0) return '0;
    c = (sxy << 16) / q;
    if (c > 65536) c = 65536;
    return 17'(65536 - c);
  endfunction

  task automatic predict_score(input logic [15:0] x, input logic [47:0] t);
    longint unsigned n, s1, s2, v, xq, sp;
    logic [1:0] bk;
    int unsigned tail;
    score_t r;
    if (p_rpos >= HIST_N) p_rpos = 0;
    p_hist[p_rpos] = x;
    if (++p_rpos == HIST_N) begin
      p_rpos = 0;
      p_wrapped = 1;
    end
    if (((t - p_last_recalc) & MASK48) > p_recalc) begin
      n = p_wrapped ? HIST_N : p_rpos;
      if (n >= MIN_SAMPLES) begin
        s1 = 0; s2 = 0;
        for (int i = 0; i < n; i++) begin
          s1 += p_hist[i];
          s2 += longint'(p_hist[i]) * p_hist[i];
        end
        v = (n * s2 - s1 * s1) / (n * (n - 1));
        p_spread = v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
      end
      p_last_recalc = t;
    end
    xq = longint'(x) << 16;
    sp = p_spread;
    if (xq <= 2 * sp) bk = 0;
    else if (xq <= 4 * sp) bk = 1;
    else bk = 2;
    if (p_count >= WIN_N) drop_oldest();
    tail = (p_head + p_count) % WIN_N;
    p_wval[tail] = x;
    p_wbkt[tail] = bk;
    p_wtime[tail] = t;
    p_count++;
    p_sums[bk] += x;
    while (p_count > 0 && ((t - p_wtime[p_head]) & MASK48) > p_twin) drop_oldest();
    r.instability = similarity_score();
    r.bucket = bk;
    r.fill = FILL_W'(p_count);
    expected_scores.push_back(r);
  endtask

  task automatic send_sample(input logic [15:0] x, input logic [47:0] t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {t, x};
    do @(posedge clk); while (!in_tready);
    predict_score(x, t);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TIME_WINDOW: p_twin = val;
      REG_RECALC:      p_recalc = val;
      REG_W_LOW:       p_wgt[0] = val[7:0];
      REG_W_MID:       p_wgt[1] = val[7:0];
      REG_W_HIGH:      p_wgt[2] = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] tw, input logic [31:0] rc,
                          input logic [7:0] wl, input logic [7:0] wm, input logic [7:0] wh);
    wait_drained();
    write_reg(REG_TIME_WINDOW, tw);
    write_reg(REG_RECALC, rc);
    write_reg(REG_W_LOW, wl);
    write_reg(REG_W_MID, wm);
    write_reg(REG_W_HIGH, wh);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_loss();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 4000));
      3: return 16'($urandom_range(8000, 40000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_sample(16'h0000, 48'd0);
    send_sample(16'hFFFF, 48'd1);
    send_sample(16'h8000, 48'd2);
    send_sample(16'h0001, 48'd3);
    send_sample(16'h5555, 48'd1_000_004);
    send_sample(16'hAAAA, 48'd3_000_000);
    send_sample(16'h1234, 48'd10);
    send_sample(16'h00FF, MASK48);
    send_sample(16'hFF00, 48'hAAAA_AAAA_AAAA);
    send_sample(16'h7FFF, 48'h5555_5555_5555);
    send_sample(16'h0F0F, 48'h5555_5555_5556);
    now_us = 48'h5555_5555_5556;
  endtask

  task automatic test_spread_recalc();
    // fill past the sample minimum, then force recomputes
    set_regs(32'hFFFF_FFFF, 32'd100, 8'd0, 8'd1, 8'd4);
    for (int i = 0; i < 80; i++) begin
      now_us = now_us + 48'($urandom_range(0, 60));
      send_sample(rand_loss(), now_us);
    end
  endtask

  task automatic test_window_full();
    set_regs(32'hFFFF_FFFF, 32'd0, 8'd255, 8'd255, 8'd255);
    for (int i = 0; i < 300; i++) begin
      now_us = now_us + 48'($urandom_range(1, 3));
      send_sample(rand_loss(), now_us);
    end
  endtask

  task automatic test_zero_window();
    set_regs(32'd0, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 40; i++) begin
      now_us = now_us + 48'($urandom_range(0, 1));
      send_sample(rand_loss(), now_us);
    end
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 0)
        set_regs($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000),
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000),
                 8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 49) == 0) now_us = 48'({$urandom, $urandom} & MASK48);
      else now_us = now_us + 48'($urandom_range(0, 120));
      send_sample(rand_loss(), now_us);
    end
  endtask

  always @(posedge clk) begin
    score_t got, want;
    cycles <= cycles + 1;
    if (rst_n && !quiet) out_tready <= ($urandom_range(0, 9) < 7);
    else out_tready <= 1'b1;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{instability: out_tdata[16:0], bucket: out_tdata[18:17], fill: out_tdata[27:19]};
      if (expected_scores.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        failed = 1'b1;
      end else begin
        want = expected_scores.pop_front();
        if (got.instability !== want.instability) begin
          $error("instability expected %0d actual %0d", want.instability, got.instability);
          failed = 1'b1;
        end
        if (got.bucket !== want.bucket) begin
          $error("bucket_chosen expected %0d actual %0d", want.bucket, got.bucket);
          failed = 1'b1;
        end
        if (got.fill !== want.fill) begin
          $error("window_fill expected %0d actual %0d", want.fill, got.fill);
          failed = 1'b1;
        end
      end
    end
    if (cycles >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_spread_recalc();
    test_window_full();
    test_zero_window();
    test_random(900);
    quiet = 1'b1;
    test_random(150);
    wait_drained();
    if (!failed) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
sv/lwss_pkg.sv
sv/lwss_ctrl.sv
sv/lwss_dp.sv
sv/loss_window_stability_scorer.sv
sim/tb_loss_window_stability_scorer.sv
